// ----- hdl/gray_dilation_boundary_3x3_defines.svh -----
// Assertion macros for the gray dilation boundary block.
// Used by gray_dilation_boundary_3x3.sv; depends on nothing else.
`ifndef GRAY_DILATION_BOUNDARY_3X3_DEFINES_SVH
`define GRAY_DILATION_BOUNDARY_3X3_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted (active low).
`define GDB_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("gdb check failed");

// Next-cycle implication, disabled while reset is asserted (active low).
`define GDB_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("gdb check failed");

`endif

// ----- hdl/gdb3_pkg.sv -----
// Types and constants of the gray dilation boundary block.
// Self-contained; used by gray_dilation_boundary_3x3.sv.
package gdb3_pkg;

  localparam int unsigned MaxWidthDefault = 2048;
  localparam int unsigned ChanW           = 8;
  localparam int unsigned WidthRegW       = 12;
  localparam int unsigned HeightRegW      = 13;
  localparam int unsigned CfgDataW        = 13;
  localparam int unsigned CfgIdxW         = 2;
  localparam int unsigned RowW            = 12;
  localparam int unsigned SumW            = 10;
  localparam int unsigned ProdW           = 19;

  localparam logic [WidthRegW-1:0]  WidthReset  = 12'd640;
  localparam logic [HeightRegW-1:0] HeightReset = 13'd480;
  localparam logic [HeightRegW-1:0] HeightLimit = 13'd4096;
  localparam logic [HeightRegW-1:0] MinDim      = 13'd3;

  // floor(x / 3) for x <= 765 as (x * 683) >> 11
  localparam logic [SumW-1:0] DivThreeMul   = 10'd683;
  localparam int unsigned     DivThreeShift = 11;

  typedef enum logic [CfgIdxW-1:0] {
    REG_WIDTH  = 2'd0,
    REG_HEIGHT = 2'd1
  } cfg_reg_e;

  typedef struct packed {
    logic [ChanW-1:0] red;
    logic [ChanW-1:0] green;
    logic [ChanW-1:0] blue;
  } pix_in_t;

  typedef struct packed {
    logic [ChanW-1:0] out_red;
    logic [ChanW-1:0] out_green;
    logic [ChanW-1:0] out_blue;
    logic             out_valid;
    logic             frame_end;
  } pix_out_t;

  typedef struct packed {
    logic valid;
    logic frame_last;
    logic interior;
  } pos_flags_t;

endpackage

// ----- hdl/gray_dilation_boundary_3x3.sv -----
// Gray dilation boundary (3x3 morphological gradient) over an RGB raster stream.
// Depends on gdb3_pkg.sv and gray_dilation_boundary_3x3_defines.svh.

// Takes one RGB pixel per beat in raster order and returns one result beat per
// input beat, at a sustained rate of one pixel per clock cycle while the output
// is not stalled. Each pixel's gray level is (r+g+b)/3; a result is the 3x3
// window maximum of gray minus each channel of the window centre, floored at
// zero, and zero on border pixels. A result belongs to the centre one row plus
// one pixel behind the current input, so the first width+1 results of a frame
// carry out_valid = 0 and the last width+1 border results of a frame are never
// produced. The previous two gray rows and the previous color row live in one
// line memory of MAX_WIDTH entries, read when a pixel is accepted and written
// back when the pixel leaves the compute stage; a result is registered in the
// compute stage and then in the output register. Width (register 0) and height
// (register 1) are clamped to 3..MAX_WIDTH and 3..4096 and take effect at once;
// write them only while the block is idle. Line memory contents after reset are
// undefined and only ever feed border results, so no clearing pass is needed.
module gray_dilation_boundary_3x3 #(
  parameter int unsigned MAX_WIDTH = gdb3_pkg::MaxWidthDefault
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  gdb3_pkg::pix_in_t                   in_data_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output gdb3_pkg::pix_out_t                  out_data_o,
  input  logic                                cfg_we_i,
  input  logic [gdb3_pkg::CfgIdxW-1:0]        cfg_index_i,
  input  logic [gdb3_pkg::CfgDataW-1:0]       cfg_data_i
);

`include "gray_dilation_boundary_3x3_defines.svh"

  localparam int unsigned AW  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int unsigned CW0 = $clog2(MAX_WIDTH + 1);
  localparam int unsigned CW  = (CW0 > gdb3_pkg::WidthRegW) ? CW0 : gdb3_pkg::WidthRegW;
  localparam int unsigned CH  = gdb3_pkg::ChanW;

  // One line memory entry: previous-row color, previous-row gray, older-row gray.
  typedef struct packed {
    logic [3*CH-1:0] color_prev;
    logic [CH-1:0]   gray_prev;
    logic [CH-1:0]   gray_older;
  } line_entry_t;

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [gdb3_pkg::WidthRegW-1:0]  width_q;
  logic [gdb3_pkg::HeightRegW-1:0] height_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= gdb3_pkg::WidthReset;
      height_q <= gdb3_pkg::HeightReset;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        gdb3_pkg::REG_WIDTH:  width_q  <= cfg_data_i[gdb3_pkg::WidthRegW-1:0];
        gdb3_pkg::REG_HEIGHT: height_q <= cfg_data_i;
        default: ;  // ignore writes past the register list
      endcase
    end
  end

  // Clamp the frame size and form the last column and last row.
  logic [CW-1:0]              w_ext, w_eff, last_col;
  logic [gdb3_pkg::HeightRegW-1:0] h_eff;
  logic [gdb3_pkg::RowW-1:0]  last_row;

  always_comb begin
    w_ext = CW'(width_q);
    if (w_ext < CW'(gdb3_pkg::MinDim)) begin
      w_eff = CW'(gdb3_pkg::MinDim);
    end else if (w_ext > CW'(MAX_WIDTH)) begin
      w_eff = CW'(MAX_WIDTH);
    end else begin
      w_eff = w_ext;
    end
    last_col = w_eff - CW'(1);

    if (height_q < gdb3_pkg::MinDim) begin
      h_eff = gdb3_pkg::MinDim;
    end else if (height_q > gdb3_pkg::HeightLimit) begin
      h_eff = gdb3_pkg::HeightLimit;
    end else begin
      h_eff = height_q;
    end
    last_row = gdb3_pkg::RowW'(h_eff - gdb3_pkg::HeightRegW'(1));
  end

  // ---------------------------------------------------------------------------
  // Handshake: compute stage advances when the output register is free or drains
  // ---------------------------------------------------------------------------
  logic s1_valid_q;
  logic out_valid_q;
  logic s1_adv, s1_fire, in_accept;

  assign s1_adv     = !out_valid_q || out_ready_i;
  assign s1_fire    = s1_valid_q && s1_adv;
  assign in_ready_o = !s1_valid_q || s1_adv;
  assign in_accept  = in_valid_i && in_ready_o;

  // ---------------------------------------------------------------------------
  // Accept stage: position counters, gray level, memory read
  // ---------------------------------------------------------------------------
  logic [AW-1:0]             col_q;
  logic [gdb3_pkg::RowW-1:0] row_q;
  logic [CW-1:0]             col_ext;
  logic                      row_end, frame_last;
  gdb3_pkg::pos_flags_t      flags_d;
  logic [gdb3_pkg::SumW-1:0] pix_sum;
  logic [gdb3_pkg::ProdW-1:0] gray_prod;
  logic [CH-1:0]             gray_d;

  always_comb begin
    col_ext    = CW'(col_q);
    row_end    = (col_ext >= last_col);
    frame_last = row_end && (row_q >= last_row);

    flags_d.valid      = !((row_q == '0) ||
                           ((row_q == gdb3_pkg::RowW'(1)) && (col_q == '0)));
    flags_d.frame_last = frame_last;
    flags_d.interior   = (row_q >= gdb3_pkg::RowW'(2)) && (row_q <= last_row) &&
                         (col_ext >= CW'(2)) && (col_ext <= last_col);

    pix_sum   = gdb3_pkg::SumW'(in_data_i.red) + gdb3_pkg::SumW'(in_data_i.green) +
                gdb3_pkg::SumW'(in_data_i.blue);
    gray_prod = gdb3_pkg::ProdW'(pix_sum) * gdb3_pkg::ProdW'(gdb3_pkg::DivThreeMul);
    gray_d    = gray_prod[gdb3_pkg::DivThreeShift +: CH];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (in_accept) begin
      if (row_end) begin
        col_q <= '0;
        row_q <= frame_last ? '0 : row_q + gdb3_pkg::RowW'(1);
      end else begin
        col_q <= col_q + AW'(1);
      end
    end
  end

  // Compute stage payload: hold while stalled.
  gdb3_pkg::pix_in_t    s1_pix_q;
  logic [CH-1:0]        s1_gray_q;
  logic [AW-1:0]        s1_idx_q;
  gdb3_pkg::pos_flags_t s1_flags_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_accept) begin
      s1_valid_q <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_pix_q   <= in_data_i;
      s1_gray_q  <= gray_d;
      s1_idx_q   <= col_q;
      s1_flags_q <= flags_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Line memory: read at accept, write back as the pixel leaves the compute
  // stage. Consecutive pixels never touch the same column, and a column comes
  // back no sooner than three pixels later, so no forwarding is needed.
  // ---------------------------------------------------------------------------
  line_entry_t line_mem [MAX_WIDTH];
  line_entry_t rd_q;
  line_entry_t wr_entry;

  assign wr_entry = '{color_prev: s1_pix_q, gray_prev: s1_gray_q, gray_older: rd_q.gray_prev};

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      rd_q <= line_mem[col_q];
    end
    if (s1_fire) begin
      line_mem[s1_idx_q] <= wr_entry;
    end
  end

  // ---------------------------------------------------------------------------
  // Compute stage: window maximum and floored differences
  // ---------------------------------------------------------------------------
  logic [CH-1:0]     win_q [6];
  logic [3*CH-1:0]   centre_q;
  logic [CH-1:0]     cand [9];
  logic [CH-1:0]     win_max;
  gdb3_pkg::pix_out_t res_d;
  gdb3_pkg::pix_in_t centre_pix;

  always_comb begin
    cand[0] = s1_gray_q;
    cand[1] = rd_q.gray_prev;
    cand[2] = rd_q.gray_older;
    for (int k = 0; k < 6; k++) begin
      cand[k+3] = win_q[k];
    end
    win_max = cand[0];
    for (int k = 1; k < 9; k++) begin
      if (cand[k] > win_max) begin
        win_max = cand[k];
      end
    end

    centre_pix = centre_q;
    res_d      = '0;
    if (s1_flags_q.valid) begin
      res_d.out_valid = 1'b1;
      res_d.frame_end = s1_flags_q.frame_last;
      if (s1_flags_q.interior) begin
        res_d.out_red   = (win_max > centre_pix.red)   ? win_max - centre_pix.red   : '0;
        res_d.out_green = (win_max > centre_pix.green) ? win_max - centre_pix.green : '0;
        res_d.out_blue  = (win_max > centre_pix.blue)  ? win_max - centre_pix.blue  : '0;
      end
    end
  end

  // Advance the column window and the pending centre as each pixel completes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < 6; k++) begin
        win_q[k] <= '0;
      end
      centre_q <= '0;
    end else if (s1_fire) begin
      win_q[3] <= win_q[0];
      win_q[4] <= win_q[1];
      win_q[5] <= win_q[2];
      win_q[0] <= rd_q.gray_older;
      win_q[1] <= rd_q.gray_prev;
      win_q[2] <= s1_gray_q;
      centre_q <= rd_q.color_prev;
    end
  end

  // ---------------------------------------------------------------------------
  // Output register
  // ---------------------------------------------------------------------------
  gdb3_pkg::pix_out_t out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_fire) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_fire) begin
      out_q <= res_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  `GDB_ASSERT_SAME(a_no_same_column, clk_i, rst_ni, s1_fire && in_accept, s1_idx_q != col_q)
  `GDB_ASSERT_NEXT(a_fire_fills_out, clk_i, rst_ni, s1_fire, out_valid_q)
  `GDB_ASSERT_NEXT(a_frame_wraps, clk_i, rst_ni, in_accept && frame_last, (col_q == '0) && (row_q == '0))
  `GDB_ASSERT_SAME(a_fill_is_zero, clk_i, rst_ni, out_valid_q && !out_q.out_valid, (out_q.out_red == '0) && (out_q.out_green == '0) && (out_q.out_blue == '0) && !out_q.frame_end)

endmodule

// ----- verif/tb_gray_dilation_boundary_3x3.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for gray_dilation_boundary_3x3: streams RGB raster frames
// and checks each result beat against a line-buffer model of the dilation gradient.
// Depends on gdb3_pkg.sv and the gray_dilation_boundary_3x3 RTL.
module testbench;
  import gdb3_pkg::*;

  localparam int unsigned LineDepth    = MaxWidthDefault;
  localparam int unsigned ReportLimit  = 10;
  // The result register sits behind the compute stage register; settle past both.
  localparam int unsigned SettleCycles = 6;
  localparam int unsigned DrainLimit   = 20000;
  localparam int unsigned RandomItems  = 1600;

  // Register indexes beyond width and height: the block must ignore writes to them.
  localparam logic [CfgIdxW-1:0] SpareIdxA = 2'd2;
  localparam logic [CfgIdxW-1:0] SpareIdxB = 2'd3;

  localparam logic [ChanW-1:0] ChanMax = 8'd255;

  localparam pix_in_t  Black     = '{8'd0, 8'd0, 8'd0};
  localparam pix_in_t  White     = '{ChanMax, ChanMax, ChanMax};
  // Typed results: no centre yet, border centre, last interior pixel of a frame.
  localparam pix_out_t NoCentre  = '0;
  localparam pix_out_t BorderOut = '{8'd0, 8'd0, 8'd0, 1'b1, 1'b0};
  localparam pix_out_t LastFlat  = '{8'd0, 8'd0, 8'd0, 1'b1, 1'b1};
  localparam pix_out_t LastPeak  = '{ChanMax, ChanMax, ChanMax, 1'b1, 1'b1};
  localparam pix_out_t Predicted = '0;

  typedef struct packed {
    pix_in_t  pix;
    logic     typed;
    pix_out_t want;
  } stim_row_t;

  // Directed frames, all 3x3. Frame one is black with a white last pixel, so the
  // only interior centre sees the full gray peak against a black centre. Frame two
  // is flat white, which must give a zero gradient. Frame three mixes values so
  // that the centre red exceeds the window peak and has to floor at zero.
  stim_row_t directed_rows [27] = '{
    '{Black, 1'b1, NoCentre}, '{Black, 1'b1, NoCentre}, '{Black, 1'b1, NoCentre},
    '{Black, 1'b1, NoCentre}, '{Black, 1'b1, BorderOut}, '{Black, 1'b1, BorderOut},
    '{Black, 1'b1, BorderOut}, '{Black, 1'b1, BorderOut}, '{White, 1'b1, LastPeak},
    '{White, 1'b1, NoCentre}, '{White, 1'b1, NoCentre}, '{White, 1'b1, NoCentre},
    '{White, 1'b1, NoCentre}, '{White, 1'b1, BorderOut}, '{White, 1'b1, BorderOut},
    '{White, 1'b1, BorderOut}, '{White, 1'b1, BorderOut}, '{White, 1'b1, LastFlat},
    '{'{8'd1, 8'd2, 8'd3}, 1'b0, Predicted},
    '{'{8'd254, 8'd255, 8'd255}, 1'b0, Predicted},
    '{'{8'd0, 8'd0, 8'd1}, 1'b0, Predicted},
    '{'{8'd200, 8'd100, 8'd0}, 1'b0, Predicted},
    '{'{8'd255, 8'd0, 8'd128}, 1'b0, Predicted},
    '{'{8'd128, 8'd128, 8'd127}, 1'b0, Predicted},
    '{'{8'd0, 8'd255, 8'd0}, 1'b0, Predicted},
    '{'{8'd85, 8'd85, 8'd86}, 1'b0, Predicted},
    '{'{8'd10, 8'd20, 8'd30}, 1'b0, Predicted}
  };

  logic                clk;
  logic                rst_n     = 1'b0;
  logic                pix_valid = 1'b0;
  logic                pix_ready;
  pix_in_t             pix_data  = '0;
  logic                res_valid;
  logic                res_ready = 1'b0;
  pix_out_t            res_data;
  logic                cfg_we    = 1'b0;
  logic [CfgIdxW-1:0]  cfg_index = '0;
  logic [CfgDataW-1:0] cfg_data  = '0;

  // Model of the block: line memories, window columns, pending centre, position.
  logic [ChanW-1:0]   gray_row_prev  [LineDepth];
  logic [ChanW-1:0]   gray_row_older [LineDepth];
  logic [3*ChanW-1:0] color_row_prev [LineDepth];
  logic [ChanW-1:0]   window_gray    [6];
  logic [3*ChanW-1:0] centre_color;
  int unsigned        col_pos;
  int unsigned        row_pos;
  logic [WidthRegW-1:0]  width_reg;
  logic [HeightRegW-1:0] height_reg;

  pix_out_t pending_gradients [$];

  bit              no_idle    = 1'b0;
  logic [ChanW-1:0] flat_level = 8'd128;
  int unsigned     errors        = 0;
  int unsigned     pixels_sent   = 0;
  int unsigned     random_sent   = 0;
  int unsigned     beats_checked = 0;
  int unsigned     frame_ends    = 0;
  int unsigned     gradient_hits = 0;
  int unsigned     settings_used = 0;

  gray_dilation_boundary_3x3 uut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (pix_valid),
    .in_ready_o (pix_ready),
    .in_data_i  (pix_data),
    .out_valid_o(res_valid),
    .out_ready_i(res_ready),
    .out_data_o (res_data),
    .cfg_we_i   (cfg_we),
    .cfg_index_i(cfg_index),
    .cfg_data_i (cfg_data)
  );

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  function automatic logic [ChanW-1:0] sat_sub(input logic [ChanW-1:0] peak,
                                               input logic [ChanW-1:0] chan);
    return (peak > chan) ? peak - chan : '0;
  endfunction

  // Advance the model by one accepted pixel and return the result beat it causes.
  function automatic pix_out_t dilation_gradient(input pix_in_t p);
    pix_out_t           res;
    logic [9:0]         sum;
    logic [ChanW-1:0]   gray;
    logic [ChanW-1:0]   older;
    logic [ChanW-1:0]   prev;
    logic [ChanW-1:0]   peak;
    logic [3*ChanW-1:0] centre;
    int unsigned        w;
    int unsigned        h;
    int unsigned        c;
    int unsigned        row;
    int unsigned        idx;
    bit                 row_end;
    bit                 frame_last;
    bit                 has_centre;
    bit                 interior;
    sum  = 10'(p.red) + 10'(p.green) + 10'(p.blue);
    gray = ChanW'(sum / 3);
    // Clamp the geometry registers to what the block supports.
    w = width_reg;
    if (w < MinDim) w = MinDim;
    if (w > LineDepth) w = LineDepth;
    h = height_reg;
    if (h < MinDim) h = MinDim;
    if (h > HeightLimit) h = HeightLimit;
    c   = col_pos;
    row = row_pos;
    idx = (c < LineDepth) ? c : LineDepth - 1;
    older  = gray_row_older[idx];
    prev   = gray_row_prev[idx];
    centre = centre_color;
    row_end    = (c >= w - 1);
    frame_last = row_end && (row >= h - 1);
    has_centre = !(row == 0 || (row == 1 && c == 0));
    interior   = (row >= 2) && (row <= h - 1) && (c >= 2) && (c <= w - 1);
    peak = gray;
    if (prev > peak) peak = prev;
    if (older > peak) peak = older;
    foreach (window_gray[k]) begin
      if (window_gray[k] > peak) peak = window_gray[k];
    end
    res = '0;
    if (has_centre) begin
      res.out_valid = 1'b1;
      res.frame_end = frame_last;
      if (interior) begin
        res.out_red   = sat_sub(peak, centre[3*ChanW-1:2*ChanW]);
        res.out_green = sat_sub(peak, centre[2*ChanW-1:ChanW]);
        res.out_blue  = sat_sub(peak, centre[ChanW-1:0]);
      end
    end
    // Shift the window one column and move the current column into the lines.
    window_gray[3] = window_gray[0];
    window_gray[4] = window_gray[1];
    window_gray[5] = window_gray[2];
    window_gray[0] = older;
    window_gray[1] = prev;
    window_gray[2] = gray;
    centre_color   = color_row_prev[idx];
    gray_row_older[idx] = prev;
    gray_row_prev[idx]  = gray;
    color_row_prev[idx] = {p.red, p.green, p.blue};
    if (row_end) begin
      col_pos = 0;
      row_pos = frame_last ? 0 : row + 1;
    end else begin
      col_pos = c + 1;
    end
    return res;
  endfunction

  // Most gaps are short, a few are long; none at all while no_idle is set.
  function automatic int unsigned pick_idle();
    int unsigned r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [ChanW-1:0] jitter(input logic [ChanW-1:0] level);
    int v;
    v = int'(level) + int'($urandom_range(0, 8)) - 4;
    if (v < 0) v = 0;
    if (v > 255) v = 255;
    return ChanW'(v);
  endfunction

  // Mix of noise, saturated channels, near-flat regions and neutral grays, so that
  // gradients land both near zero and near full scale.
  function automatic pix_in_t random_pixel();
    pix_in_t     p;
    int unsigned kind;
    kind    = $urandom_range(0, 9);
    p.red   = ChanW'($urandom);
    p.green = ChanW'($urandom);
    p.blue  = ChanW'($urandom);
    if (kind == 5) begin
      p.red   = $urandom_range(0, 1) ? ChanMax : '0;
      p.green = $urandom_range(0, 1) ? ChanMax : '0;
      p.blue  = $urandom_range(0, 1) ? ChanMax : '0;
    end else if (kind >= 6 && kind <= 8) begin
      if ($urandom_range(0, 31) == 0) flat_level = ChanW'($urandom);
      p.red   = jitter(flat_level);
      p.green = jitter(flat_level);
      p.blue  = jitter(flat_level);
    end else if (kind == 9) begin
      p.green = p.red;
      p.blue  = p.red;
    end
    return p;
  endfunction

  function automatic void note_error(input string msg);
    errors++;
    if (errors <= ReportLimit) $display("[%0t] mismatch: %s", $time, msg);
  endfunction

  // Write width then height on back-to-back edges, optionally followed by a write
  // to an unused index. Call only while the block is empty.
  task automatic program_geometry(input logic [CfgDataW-1:0] wd,
                                  input logic [CfgDataW-1:0] hd,
                                  input bit spare);
    logic [CfgIdxW-1:0]  spare_idx;
    logic [CfgDataW-1:0] spare_val;
    spare_idx = $urandom_range(0, 1) ? SpareIdxA : SpareIdxB;
    spare_val = CfgDataW'($urandom);
    cfg_we    <= 1'b1;
    cfg_index <= REG_WIDTH;
    cfg_data  <= wd;
    @(posedge clk);
    cfg_index <= REG_HEIGHT;
    cfg_data  <= hd;
    @(posedge clk);
    if (spare) begin
      cfg_index <= spare_idx;
      cfg_data  <= spare_val;
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    // The width register is 12 bits wide, so the top data bit is dropped.
    width_reg  = wd[WidthRegW-1:0];
    height_reg = hd;
    settings_used++;
  endtask

  // Present one pixel beat and hold it until accepted. Return at the accepting
  // edge with valid still high, so a back-to-back beat needs no second update.
  task automatic send_pixel(input pix_in_t p, input logic typed, input pix_out_t want);
    int unsigned gap;
    pix_out_t    model_out;
    gap = pick_idle();
    if (gap != 0) begin
      pix_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    pix_valid <= 1'b1;
    pix_data  <= p;
    @(posedge clk);
    while (!pix_ready) @(posedge clk);
    model_out = dilation_gradient(p);
    pending_gradients.push_back(typed ? want : model_out);
    pixels_sent++;
  endtask

  // Drop valid, hold off until every expected beat has come, then let the
  // pipeline settle before anything else is touched.
  task automatic drain_results(input int unsigned limit);
    int unsigned waited;
    pix_valid <= 1'b0;
    waited = 0;
    while (pending_gradients.size() != 0 && waited < limit) begin
      @(posedge clk);
      waited++;
    end
    repeat (SettleCycles) @(posedge clk);
  endtask

  // Compare each result beat with the oldest expectation, field by field.
  task automatic check_result(input pix_out_t got);
    pix_out_t want;
    if (pending_gradients.size() == 0) begin
      note_error($sformatf("result beat %h with nothing expected", got));
      return;
    end
    want = pending_gradients.pop_front();
    beats_checked++;
    if (want.frame_end) frame_ends++;
    if (want.out_red != 0 || want.out_green != 0 || want.out_blue != 0) gradient_hits++;
    if (got.out_red !== want.out_red || got.out_green !== want.out_green ||
        got.out_blue !== want.out_blue || got.out_valid !== want.out_valid ||
        got.frame_end !== want.frame_end) begin
      note_error($sformatf(
          "got rgb %0d/%0d/%0d valid %b end %b, expected rgb %0d/%0d/%0d valid %b end %b",
          got.out_red, got.out_green, got.out_blue, got.out_valid, got.frame_end,
          want.out_red, want.out_green, want.out_blue, want.out_valid, want.frame_end));
    end
  endtask

  // Sample the result handshake at the edge; both sides only change by NBA.
  always @(posedge clk) begin
    if (rst_n && res_valid && res_ready) check_result(res_data);
  end

  // Result side: random stalls between runs of ready, long ones now and then.
  initial begin : result_sink
    int unsigned stall;
    int unsigned hold;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      stall = pick_idle();
      if (stall != 0) begin
        res_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      res_ready <= 1'b1;
      hold = $urandom_range(1, 8);
      repeat (hold) @(posedge clk);
    end
  end

  initial begin : stimulus
    logic [CfgDataW-1:0] wd;
    logic [CfgDataW-1:0] hd;
    int unsigned         r;
    int unsigned         count;
    int unsigned         phase;
    int unsigned         n;
    // Mirror the reset state; line memories are zero in the model, and any entry
    // never written only ever feeds a border result.
    foreach (gray_row_prev[i]) begin
      gray_row_prev[i]  = '0;
      gray_row_older[i] = '0;
      color_row_prev[i] = '0;
    end
    foreach (window_gray[i]) window_gray[i] = '0;
    centre_color = '0;
    col_pos      = 0;
    row_pos      = 0;
    width_reg    = WidthReset;
    height_reg   = HeightReset;

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part: three 3x3 frames.
    program_geometry(13'd3, 13'd3, 1'b1);
    foreach (directed_rows[i]) begin
      send_pixel(directed_rows[i].pix, directed_rows[i].typed, directed_rows[i].want);
    end
    drain_results(DrainLimit);

    // Random part: a new geometry per phase, mostly small frames. Phases end at
    // arbitrary positions, so a new width or height often lands mid-row or with
    // the counters already past the new last column or row.
    phase = 0;
    while (random_sent < RandomItems) begin
      r = $urandom_range(0, 99);
      if (r < 70) wd = $urandom_range(3, 12);
      else if (r < 78) wd = $urandom_range(13, 40);
      else if (r < 86) wd = $urandom_range(0, 2);
      else if (r < 92) wd = 3;
      else if (r < 96) wd = LineDepth;
      else wd = $urandom_range(LineDepth + 1, 4095);
      wd[WidthRegW] = $urandom_range(0, 1);
      r = $urandom_range(0, 99);
      if (r < 60) hd = $urandom_range(3, 8);
      else if (r < 75) hd = $urandom_range(9, 20);
      else if (r < 85) hd = $urandom_range(0, 2);
      else if (r < 92) hd = 3;
      else hd = $urandom_range(4096, 8191);
      program_geometry(wd, hd, $urandom_range(0, 1));
      no_idle = ($urandom_range(0, 3) == 0);
      count = $urandom_range(20, 250);
      for (n = 0; n < count; n++) begin
        send_pixel(random_pixel(), 1'b0, Predicted);
        random_sent++;
        // Once, hold the sender mid-phase until the block has emptied.
        if (phase == 3 && n == count / 2) drain_results(DrainLimit);
      end
      drain_results(DrainLimit);
      phase++;
    end

    // Widest line (width clamped down from 4095) with the shortest frame.
    program_geometry(13'd4095, 13'd0, 1'b0);
    no_idle = 1'b0;
    repeat (3 * LineDepth) send_pixel(random_pixel(), 1'b0, Predicted);
    drain_results(DrainLimit);

    // Narrowest line with the tallest frame (height clamped down from 8191).
    program_geometry(13'd0, 13'd8191, 1'b1);
    no_idle = 1'b1;
    repeat (3 * int'(HeightLimit)) send_pixel(random_pixel(), 1'b0, Predicted);
    drain_results(DrainLimit);

    if (pending_gradients.size() != 0) begin
      errors += pending_gradients.size();
      $display("%0d expected result beats never arrived", pending_gradients.size());
    end
    $display("covered %0d pixels over %0d geometry settings, %0d result beats, %0d frame ends",
             pixels_sent, settings_used, beats_checked, frame_ends);
    $display("%0d interior beats carried a nonzero gradient; widths 3 to %0d, heights 3 to %0d",
             gradient_hits, LineDepth, HeightLimit);
    if (errors == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

  // Hang guard, several times the slowest legal run.
  initial begin : watchdog
    #15_000_000;
    $display("watchdog expired with %0d beats outstanding", pending_gradients.size());
    $display("testbench: done, errors");
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+hdl
hdl/gdb3_pkg.sv
hdl/gray_dilation_boundary_3x3.sv
verif/tb_gray_dilation_boundary_3x3.sv
